@@ design/ctcgd_pkg.sv @@
// ctcgd_pkg: types and constants shared by the ctc greedy decoder modules
// no dependencies; compile first

package ctcgd_pkg;

    // field widths
    localparam int LOGIT_BITS  = 16;
    localparam int CLASS_BITS  = 13;
    localparam int KEPT_BITS   = 11;
    localparam int DICT_BITS   = 14;
    localparam int OUT_DATA_BITS = 40;
    localparam int OUT_USER_BITS = 2;

    // class scan limits
    localparam int MAX_CLASSES = 8192;
    localparam int CNT_BITS    = 14;

    // kept step limits and running sum
    localparam int MAX_STEPS   = 1024;
    localparam int SUM_BITS    = 27;
    localparam int MAG_BITS    = 26;
    localparam int ITER_BITS   = 5;
    localparam int REM_BITS    = 11;

    // dictionary size after reset
    localparam logic [DICT_BITS-1:0] DICT_RESET = 14'd8192;

    // step queue between front and back
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    // one finished timestep as handed from front to back
    typedef struct packed {
        logic [CLASS_BITS-1:0]        cls;
        logic signed [LOGIT_BITS-1:0] value;
        logic                         keep;
        logic                         seq_end;
    } step_rec_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CLASS,
        BK_DIV,
        BK_SUM
    } back_state_t;

endpackage

@@ design/ctcgd_front.sv @@
// ctcgd_front: per-timestep arg-max scan, repeat collapse and blank drop
// depends on ctcgd_pkg; pushes one step record per kept step or sequence end

module ctcgd_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_accept,
    input  logic signed [ctcgd_pkg::LOGIT_BITS-1:0] logit,
    input  logic                                   row_end,
    input  logic                                   seq_end,
    output logic                                   rec_push,
    output ctcgd_pkg::step_rec_t                   rec_data
);

    logic [ctcgd_pkg::CNT_BITS-1:0]          counter_reg, counter_next;
    logic [ctcgd_pkg::CLASS_BITS-1:0]        best_class_reg, best_class_next;
    logic signed [ctcgd_pkg::LOGIT_BITS-1:0] best_value_reg, best_value_next;
    logic [ctcgd_pkg::CLASS_BITS-1:0]        prev_class_reg, prev_class_next;
    logic                                    prev_valid_reg, prev_valid_next;

    logic                                    in_range;
    logic                                    take;
    logic [ctcgd_pkg::CLASS_BITS-1:0]        cand_class;
    logic signed [ctcgd_pkg::LOGIT_BITS-1:0] cand_value;
    logic                                    keep;

    // running arg-max, first index wins on a tie
    assign in_range   = counter_reg < ctcgd_pkg::CNT_BITS'(ctcgd_pkg::MAX_CLASSES);
    assign take       = in_range && ((counter_reg == '0) || (logit > best_value_reg));
    assign cand_class = take ? counter_reg[ctcgd_pkg::CLASS_BITS-1:0] : best_class_reg;
    assign cand_value = take ? logit : best_value_reg;

    // collapse repeats, then drop blank
    assign keep = !(prev_valid_reg && (cand_class == prev_class_reg)) && (cand_class != '0);

    assign rec_push         = in_accept && row_end && (keep || seq_end);
    assign rec_data.cls     = cand_class;
    assign rec_data.value   = cand_value;
    assign rec_data.keep    = keep;
    assign rec_data.seq_end = seq_end;

    // next state
    always_comb begin
        counter_next    = counter_reg;
        best_class_next = best_class_reg;
        best_value_next = best_value_reg;
        prev_class_next = prev_class_reg;
        prev_valid_next = prev_valid_reg;
        if (in_accept) begin
            if (row_end) begin
                counter_next    = '0;
                best_class_next = '0;
                best_value_next = '0;
                if (seq_end) begin
                    prev_class_next = '0;
                    prev_valid_next = 1'b0;
                end else begin
                    prev_class_next = cand_class;
                    prev_valid_next = 1'b1;
                end
            end else begin
                counter_next    = counter_reg + ctcgd_pkg::CNT_BITS'(in_range);
                best_class_next = cand_class;
                best_value_next = cand_value;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg    <= '0;
            best_class_reg <= '0;
            best_value_reg <= '0;
            prev_class_reg <= '0;
            prev_valid_reg <= 1'b0;
        end else begin
            counter_reg    <= counter_next;
            best_class_reg <= best_class_next;
            best_value_reg <= best_value_next;
            prev_class_reg <= prev_class_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

endmodule

@@ design/ctcgd_fifo.sv @@
// ctcgd_fifo: small register queue of step records between front and back
// depends on ctcgd_pkg

module ctcgd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ctcgd_pkg::step_rec_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output ctcgd_pkg::step_rec_t pop_data
);

    ctcgd_pkg::step_rec_t                  mem_reg [ctcgd_pkg::FIFO_DEPTH];
    logic [ctcgd_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ctcgd_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ctcgd_pkg::FIFO_CNT_BITS-1:0]   count_reg, count_next;
    logic                                  do_push;
    logic                                  do_pop;

    function automatic logic [ctcgd_pkg::FIFO_PTR_BITS-1:0] FIFO_PTR_ONE(input logic b);
        return ctcgd_pkg::FIFO_PTR_BITS'(b);
    endfunction

    assign full      = count_reg == ctcgd_pkg::FIFO_CNT_BITS'(ctcgd_pkg::FIFO_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_ONE(do_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_ONE(do_pop);
        count_next  = count_reg + ctcgd_pkg::FIFO_CNT_BITS'(do_push)
                                - ctcgd_pkg::FIFO_CNT_BITS'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/ctcgd_back.sv @@
// ctcgd_back: score accumulation, bit-serial mean divider and result register
// depends on ctcgd_pkg; drains step records from ctcgd_fifo

module ctcgd_back (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    rec_valid,
    input  ctcgd_pkg::step_rec_t                    rec_data,
    output logic                                    rec_pop,
    input  logic                                    cfg_we,
    input  logic [ctcgd_pkg::DICT_BITS-1:0]         cfg_wdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [ctcgd_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    output logic [ctcgd_pkg::OUT_USER_BITS-1:0]     m_tuser,
    output logic                                    m_tlast
);

    localparam int CB = ctcgd_pkg::CLASS_BITS;
    localparam int LB = ctcgd_pkg::LOGIT_BITS;
    localparam int KB = ctcgd_pkg::KEPT_BITS;
    localparam int SB = ctcgd_pkg::SUM_BITS;
    localparam int MB = ctcgd_pkg::MAG_BITS;
    localparam int RB = ctcgd_pkg::REM_BITS;
    localparam int IB = ctcgd_pkg::ITER_BITS;

    ctcgd_pkg::back_state_t state_reg, state_next;

    logic [ctcgd_pkg::DICT_BITS-1:0] dict_reg;
    logic [CB-1:0]                   cls_reg, cls_next;
    logic                            seq_reg, seq_next;
    logic signed [SB-1:0]            sum_reg, sum_next;
    logic [KB-1:0]                   kept_reg, kept_next;
    logic [RB-1:0]                   rem_reg, rem_next;
    logic [MB-1:0]                   quo_reg, quo_next;
    logic                            neg_reg, neg_next;
    logic [IB-1:0]                   iter_reg, iter_next;

    logic                            out_valid_reg, out_valid_next;
    logic [CB-1:0]                   out_cls_reg, out_cls_next;
    logic                            out_text_reg, out_text_next;
    logic                            out_summ_reg, out_summ_next;
    logic [LB-1:0]                   out_score_reg, out_score_next;
    logic [KB-1:0]                   out_kept_reg, out_kept_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            out_load;
    logic [SB-1:0]                   sum_abs;
    logic [RB:0]                     rem_shift;
    logic [RB:0]                     divisor;
    logic                            rem_ge;
    logic [LB-1:0]                   mean;

    assign out_free = !out_valid_reg || m_tready;

    // magnitude of the sum for sign-magnitude division (truncates toward zero)
    assign sum_abs = sum_reg[SB-1] ? SB'(-sum_reg) : SB'(sum_reg);

    // one restoring division step
    assign rem_shift = {rem_reg, quo_reg[MB-1]};
    assign divisor   = (RB+1)'(kept_reg);
    assign rem_ge    = rem_shift >= divisor;
    assign mean      = (kept_reg == '0) ? '0
                     : (neg_reg ? LB'(-quo_reg[LB-1:0]) : quo_reg[LB-1:0]);

    // sequencer and datapath next values
    always_comb begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        seq_next       = seq_reg;
        sum_next       = sum_reg;
        kept_next      = kept_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        iter_next      = iter_reg;
        rec_pop        = 1'b0;
        out_load       = 1'b0;
        out_cls_next   = out_cls_reg;
        out_text_next  = out_text_reg;
        out_summ_next  = out_summ_reg;
        out_score_next = out_score_reg;
        out_kept_next  = out_kept_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ctcgd_pkg::BK_IDLE: begin
                if (rec_valid) begin
                    rec_pop  = 1'b1;
                    cls_next = rec_data.cls;
                    seq_next = rec_data.seq_end;
                    if (rec_data.keep) begin
                        // count and sum only up to the step limit
                        if (kept_reg < KB'(ctcgd_pkg::MAX_STEPS)) begin
                            sum_next  = sum_reg + SB'(rec_data.value);
                            kept_next = kept_reg + KB'(1);
                        end
                        state_next = ctcgd_pkg::BK_CLASS;
                    end else begin
                        neg_next   = sum_reg[SB-1];
                        quo_next   = sum_abs[MB-1:0];
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ctcgd_pkg::BK_DIV;
                    end
                end
            end
            ctcgd_pkg::BK_CLASS: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_cls_next   = cls_reg;
                    out_text_next  = {1'b0, cls_reg} < dict_reg;
                    out_summ_next  = 1'b0;
                    out_score_next = '0;
                    out_kept_next  = kept_reg;
                    out_last_next  = 1'b0;
                    if (seq_reg) begin
                        neg_next   = sum_reg[SB-1];
                        quo_next   = sum_abs[MB-1:0];
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ctcgd_pkg::BK_DIV;
                    end else begin
                        state_next = ctcgd_pkg::BK_IDLE;
                    end
                end
            end
            ctcgd_pkg::BK_DIV: begin
                rem_next  = rem_ge ? RB'(rem_shift - divisor) : rem_shift[RB-1:0];
                quo_next  = {quo_reg[MB-2:0], rem_ge};
                iter_next = iter_reg + IB'(1);
                if (iter_reg == IB'(MB - 1)) begin
                    state_next = ctcgd_pkg::BK_SUM;
                end
            end
            ctcgd_pkg::BK_SUM: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_cls_next   = '0;
                    out_text_next  = 1'b0;
                    out_summ_next  = 1'b1;
                    out_score_next = mean;
                    out_kept_next  = kept_reg;
                    out_last_next  = 1'b1;
                    sum_next       = '0;
                    kept_next      = '0;
                    state_next     = ctcgd_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = ctcgd_pkg::BK_IDLE;
            end
        endcase

        // result register valid
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ctcgd_pkg::BK_IDLE;
            dict_reg      <= ctcgd_pkg::DICT_RESET;
            sum_reg       <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                dict_reg <= cfg_wdata;
            end
        end
    end

    // payload and divider registers
    always_ff @(posedge aclk) begin
        cls_reg       <= cls_next;
        seq_reg       <= seq_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        iter_reg      <= iter_next;
        out_cls_reg   <= out_cls_next;
        out_text_reg  <= out_text_next;
        out_summ_reg  <= out_summ_next;
        out_score_reg <= out_score_next;
        out_kept_reg  <= out_kept_next;
        out_last_reg  <= out_last_next;
    end

    // result beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_kept_reg, out_score_reg, out_cls_reg};
    assign m_tuser  = {out_summ_reg, out_text_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ design/ctc_greedy_decoder_unit.sv @@
// ctc_greedy_decoder_unit: top level of the ctc greedy best-path decoder
// depends on ctcgd_pkg, ctcgd_front, ctcgd_fifo, ctcgd_back
//
//   channel | direction | tdata                                   | tuser                    | tlast
//   s_      | in        | [15:0] logit                            | [0] seq_end              | row_end
//   m_      | out       | [12:0] class_index [28:13] score        | [0] has_text             | last
//           |           | [39:29] kept_count                      | [1] is_summary           |
//   cfg_    | in        | cfg_wdata [13:0] dict_entries, cfg_we   |                          |
//
// the front takes one logit beat per cycle unless the step queue is full, one class per beat
// the back handles each kept step through its class state, and each summary through the
// one-bit-per-cycle divider for the mean and its summary state; a four-entry step queue between
// them lets the input run on while the back divides or the output stalls
// s_tready drops only while the step queue is full
// synchronous active-low reset; no clearing pass, ready right after reset

module ctc_greedy_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] logit
    input  logic [0:0]  s_tuser,   // [0] seq_end
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [12:0] class_index, [28:13] score, [39:29] kept_count
    output logic [1:0]  m_tuser,   // [0] has_text, [1] is_summary
    output logic        m_tlast,
    // configuration
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata
);

    logic                 in_accept;
    logic                 rec_push;
    ctcgd_pkg::step_rec_t push_data;
    logic                 fifo_full;
    logic                 rec_pop;
    logic                 rec_valid;
    ctcgd_pkg::step_rec_t pop_data;

    assign s_tready  = !fifo_full;
    assign in_accept = s_tvalid && s_tready;

    // scan and classify
    ctcgd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .logit     (s_tdata),
        .row_end   (s_tlast),
        .seq_end   (s_tuser[0]),
        .rec_push  (rec_push),
        .rec_data  (push_data)
    );

    // step queue
    ctcgd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (rec_pop),
        .pop_valid (rec_valid),
        .pop_data  (pop_data)
    );

    // accumulate, divide and emit
    ctcgd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_data  (pop_data),
        .rec_pop   (rec_pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
